>>> rtl/hvt_pkg.sv
// Shared types and constants for the homogeneous vertex transform.
// No dependencies; imported by homogeneous_vertex_transform and tb_top.
package hvt_pkg;

  localparam int unsigned FRAC_BITS_DEF = 16;
  localparam int unsigned NUM_REGS      = 8;
  localparam int unsigned CFG_IDX_W     = 3;
  localparam int unsigned REG_W         = 64;
  localparam int unsigned COORD_W       = 32;
  localparam int unsigned DIV_STEPS     = 32;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ROW0_C01 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROW0_C23 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROW1_C01 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ROW1_C23 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ROW2_C01 = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ROW2_C23 = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_ROW3_C01 = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_ROW3_C23 = 3'd7;

  // One divider lane: partial remainder, quotient so far, dividend bits still
  // to shift in, and the per-lane flags.
  typedef struct packed {
    logic [63:0] rem;
    logic [31:0] quo;
    logic [31:0] lo;
    logic        ovf;
    logic        nz;
    logic        neg;
  } lane_t;

  typedef struct packed {
    lane_t [2:0] lane;
    logic [63:0] den;
    logic        zero_w;
  } div_t;

endpackage

>>> rtl/homogeneous_vertex_transform.sv
// Throughput: one vertex per cycle while the skid register is empty (else stalled);
// 12 32x32 multipliers, a four-way row sum and three 32-step restoring dividers
// (one quotient bit per stage) form the datapath.
// Output register plus skid register; s_axis_tready is registered.
// Reset (rst_ni low, async) clears all valid bits and loads the identity matrix.
// Depends on hvt_pkg.
module homogeneous_vertex_transform #(
  parameter int unsigned FRAC_BITS = hvt_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [hvt_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [hvt_pkg::REG_W-1:0]     cfg_data_i,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [95:0]                   s_axis_tdata,  // in_x, in_y, in_z
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [95:0]                   m_axis_tdata,  // out_x, out_y, out_z
  output logic [1:0]                    m_axis_tuser   // zero_w, saturated
);
  import hvt_pkg::*;

  localparam logic [63:0] ONE_FX = 64'(1) << FRAC_BITS;

  logic        en;
  logic [63:0] mat_q [NUM_REGS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mat_q[0] <= ONE_FX;
      mat_q[1] <= '0;
      mat_q[2] <= ONE_FX << 32;
      mat_q[3] <= '0;
      mat_q[4] <= '0;
      mat_q[5] <= ONE_FX;
      mat_q[6] <= '0;
      mat_q[7] <= ONE_FX << 32;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_ROW0_C01: mat_q[0] <= cfg_data_i;
        REG_ROW0_C23: mat_q[1] <= cfg_data_i;
        REG_ROW1_C01: mat_q[2] <= cfg_data_i;
        REG_ROW1_C23: mat_q[3] <= cfg_data_i;
        REG_ROW2_C01: mat_q[4] <= cfg_data_i;
        REG_ROW2_C23: mat_q[5] <= cfg_data_i;
        REG_ROW3_C01: mat_q[6] <= cfg_data_i;
        REG_ROW3_C23: mat_q[7] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic signed [31:0] m_el [4][4];
  always_comb begin
    for (int r = 0; r < 4; r++) begin
      m_el[r][0] = mat_q[2*r][31:0];
      m_el[r][1] = mat_q[2*r][63:32];
      m_el[r][2] = mat_q[2*r+1][31:0];
      m_el[r][3] = mat_q[2*r+1][63:32];
    end
  end

  // ---------------- valid bits ----------------
  logic a_vld_q, b_vld_q, c_vld_q, d_vld_q;
  logic dv_vld_q [DIV_STEPS+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
      b_vld_q <= 1'b0;
      c_vld_q <= 1'b0;
      d_vld_q <= 1'b0;
      for (int k = 0; k <= DIV_STEPS; k++) dv_vld_q[k] <= 1'b0;
    end else if (en) begin
      a_vld_q <= s_axis_tvalid;
      b_vld_q <= a_vld_q;
      c_vld_q <= b_vld_q;
      d_vld_q <= c_vld_q;
      dv_vld_q[0] <= d_vld_q;
      for (int k = 0; k < DIV_STEPS; k++) dv_vld_q[k+1] <= dv_vld_q[k];
    end
  end

  // ---------------- stage A: input ----------------
  logic signed [31:0] v_q [3];
  always_ff @(posedge clk_i) begin
    if (en) begin
      v_q[0] <= s_axis_tdata[31:0];
      v_q[1] <= s_axis_tdata[63:32];
      v_q[2] <= s_axis_tdata[95:64];
    end
  end

  // ---------------- stage B: products ----------------
  logic signed [63:0] prod_q [4][3];
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int r = 0; r < 4; r++)
        for (int c = 0; c < 3; c++) prod_q[r][c] <= m_el[r][c] * v_q[c];
    end
  end

  // ---------------- stage C: row sums ----------------
  logic signed [65:0] sum_d [4];
  logic signed [65:0] sum_q [4];
  always_comb begin
    for (int r = 0; r < 4; r++) begin
      sum_d[r] = 66'(prod_q[r][0]) + 66'(prod_q[r][1]) + 66'(prod_q[r][2])
               + (66'(m_el[r][3]) <<< FRAC_BITS);
    end
  end
  always_ff @(posedge clk_i) begin
    if (en) sum_q <= sum_d;
  end

  // ---------------- stage D: sign and magnitude ----------------
  logic [63:0] mag_q [4];
  logic        sgn_q [4];
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int r = 0; r < 4; r++) begin
        sgn_q[r] <= sum_q[r][65];
        mag_q[r] <= sum_q[r][65] ? 64'(-sum_q[r]) : sum_q[r][63:0];
      end
    end
  end

  // ---------------- divider: init then one quotient bit per stage ----------------
  div_t dv_q [DIV_STEPS+1];
  div_t dv_init;
  always_comb begin
    logic [63:0] top;
    dv_init.den    = mag_q[3];
    dv_init.zero_w = (mag_q[3] == '0);
    for (int l = 0; l < 3; l++) begin
      top = mag_q[l] >> (32 - FRAC_BITS);
      dv_init.lane[l].ovf = (top >= mag_q[3]);  // quotient >= 2^32
      dv_init.lane[l].rem = dv_init.lane[l].ovf ? '0 : top;
      dv_init.lane[l].quo = '0;
      dv_init.lane[l].lo  = mag_q[l][31:0] << FRAC_BITS;
      dv_init.lane[l].nz  = (mag_q[l] != '0);
      dv_init.lane[l].neg = sgn_q[l] ^ sgn_q[3];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) dv_q[0] <= dv_init;
  end

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
    div_t nxt;
    always_comb begin
      logic [64:0] r2;
      nxt = dv_q[k];
      for (int l = 0; l < 3; l++) begin
        r2 = {dv_q[k].lane[l].rem, dv_q[k].lane[l].lo[31]};
        nxt.lane[l].lo = dv_q[k].lane[l].lo << 1;
        if (r2 >= {1'b0, dv_q[k].den}) begin
          nxt.lane[l].rem = 64'(r2 - {1'b0, dv_q[k].den});
          nxt.lane[l].quo = {dv_q[k].lane[l].quo[30:0], 1'b1};
        end else begin
          nxt.lane[l].rem = r2[63:0];
          nxt.lane[l].quo = {dv_q[k].lane[l].quo[30:0], 1'b0};
        end
      end
    end
    always_ff @(posedge clk_i) begin
      if (en) dv_q[k+1] <= nxt;
    end
  end

  // ---------------- saturate and sign ----------------
  logic [95:0] res_data;
  logic [1:0]  res_user;
  always_comb begin
    logic [31:0] lim, val;
    logic        clamp, any;
    lane_t       ln;
    any = 1'b0;
    for (int l = 0; l < 3; l++) begin
      ln    = dv_q[DIV_STEPS].lane[l];
      lim   = ln.neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
      clamp = ln.nz && (ln.ovf || (ln.quo > lim));
      val   = !ln.nz ? '0 : (clamp ? lim : ln.quo);
      res_data[32*l +: 32] = ln.neg ? 32'(-val) : val;
      any = any | clamp;
    end
    res_user = {any, dv_q[DIV_STEPS].zero_w};
  end

  // ---------------- output register and skid ----------------
  logic        out_vld_q, skid_vld_q;
  logic [95:0] out_data_q, skid_data_q;
  logic [1:0]  out_user_q, skid_user_q;
  logic        last_vld;

  assign last_vld      = dv_vld_q[DIV_STEPS];
  assign en            = !skid_vld_q;
  assign s_axis_tready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (en) begin
      if (!out_vld_q || m_axis_tready) out_vld_q <= last_vld;
      else if (last_vld)               skid_vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      skid_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      if (!out_vld_q || m_axis_tready) begin
        out_data_q <= res_data;
        out_user_q <= res_user;
      end else begin
        skid_data_q <= res_data;
        skid_user_q <= res_user;
      end
    end else if (m_axis_tready) begin
      out_data_q <= skid_data_q;
      out_user_q <= skid_user_q;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

  // ---------------- assertions ----------------
  a_skid_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_vld_q |-> out_vld_q)
    else $error("skid holds a request while output register is empty");

  a_zero_w_clamps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser[0]) |->
      (m_axis_tuser[1] || m_axis_tdata == '0))
    else $error("zero w without clamp on a nonzero component");

  a_stall_freezes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(dv_vld_q[DIV_STEPS]) && $stable(d_vld_q))
    else $error("pipeline moved during stall");

endmodule

>>> tb/tb_top.sv
// Self-checking bench for homogeneous_vertex_transform: directed table, directed corner cases, then random vertices.
// Expected points come from a local matrix/divide predictor; depends on hvt_pkg and the DUT.
`timescale 1ns / 100ps

module tb_top;
  import hvt_pkg::*;

  localparam int FB = int'(FRAC_BITS_DEF);
  localparam int N_RANDOM = 1930;
  localparam int LIMIT_CYC = 400000;

  typedef struct packed {
    logic [31:0] x, y, z;
    logic        zw, sat;
  } point_t;

  typedef struct {
    logic [31:0] x, y, z;
    bit          has_exp;
    point_t      exp_pt;
  } row_t;

  logic clk_i = 0, rst_ni = 0;
  logic cfg_we_i = 0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [REG_W-1:0] cfg_data_i = '0;
  logic s_axis_tvalid = 0, s_axis_tready;
  logic [95:0] s_axis_tdata = '0;
  logic m_axis_tvalid, m_axis_tready = 0;
  logic [95:0] m_axis_tdata;
  logic [1:0] m_axis_tuser;

  homogeneous_vertex_transform DUT (.*);

  always begin
    #5 clk_i = 1;
    #5 clk_i = 0;
  end

  logic [63:0] mat_regs [NUM_REGS];
  point_t pending_pts [$];
  int errors = 0;
  int cycles = 0;
  bit calm = 0;       // no idling on either side
  int hold_rx = 0;    // long receiver stall
  bit quit_rx = 0;

  function automatic logic signed [31:0] elem(int r, int c);
    logic [63:0] w;
    w = mat_regs[2 * r + c / 2];
    return (c % 2) ? w[63:32] : w[31:0];
  endfunction

  // Signed quotient num*2^FB/den truncated toward zero, clamped to 32 bits.
  function automatic logic [31:0] proj_div(logic signed [127:0] num,
                                           logic signed [127:0] den, ref bit clamp);
    logic signed [127:0] q;
    if (num == 0) return 32'd0;
    if (den == 0) begin
      clamp = 1;
      return (num > 0) ? 32'h7FFFFFFF : 32'h80000000;
    end
    q = (num <<< FB) / den;
    if (q > 128'sh7FFFFFFF) begin clamp = 1; return 32'h7FFFFFFF; end
    if (q < -128'sh80000000) begin clamp = 1; return 32'h80000000; end
    return q[31:0];
  endfunction

  function automatic point_t project_vertex(logic [31:0] x, y, z);
    logic signed [127:0] v [4];
    logic signed [127:0] s [4];
    point_t p;
    bit clamp;
    clamp = 0;
    v[0] = $signed(x); v[1] = $signed(y); v[2] = $signed(z); v[3] = 128'sd1 <<< FB;
    for (int r = 0; r < 4; r++) begin
      s[r] = 0;
      for (int c = 0; c < 4; c++) s[r] += 128'(elem(r, c)) * v[c];
    end
    p.x = proj_div(s[0], s[3], clamp);
    p.y = proj_div(s[1], s[3], clamp);
    p.z = proj_div(s[2], s[3], clamp);
    p.zw = (s[3] == 0);
    p.sat = clamp;
    return p;
  endfunction

  task automatic write_reg(int idx, logic [63:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1; cfg_idx_i <= CFG_IDX_W'(idx); cfg_data_i <= val;
    mat_regs[idx] = val;
    @(posedge clk_i);
    cfg_we_i <= 0;
  endtask

  task automatic drain();
    while (pending_pts.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
  endtask

  task automatic send_vertex(logic [31:0] x, y, z);
    while (!calm && $urandom_range(99) < 13) begin
      s_axis_tvalid <= 0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1;
    s_axis_tdata <= {z, y, x};
    pending_pts.insert(pending_pts.size(), project_vertex(x, y, z));
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  function automatic logic [31:0] rnd_coord();
    case ($urandom_range(5))
      0: return $urandom();
      1: return {{15{1'($urandom_range(1))}}, 17'($urandom())};
      2: return 32'($signed($urandom_range(8)) - 4) <<< FB;
      3: return $urandom_range(1) ? 32'h7FFFFFFF : 32'h80000000;
      default: return {{12{1'($urandom_range(1))}}, 20'($urandom())};
    endcase
  endfunction

  function automatic logic [31:0] rnd_elem();
    case ($urandom_range(4))
      0: return $urandom();
      1: return 32'($signed($urandom_range(4)) - 2) <<< FB;
      2: return 32'd0;
      default: return {{14{1'($urandom_range(1))}}, 18'($urandom())};
    endcase
  endfunction

  // Receiver and checker
  always @(posedge clk_i) begin
    point_t got, want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = {m_axis_tdata[31:0], m_axis_tdata[63:32], m_axis_tdata[95:64],
               m_axis_tuser[0], m_axis_tuser[1]};
        if (pending_pts.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result %h", got);
        end else begin
          want = pending_pts.pop_front();
          if (got !== want) begin
            errors++;
            if (errors <= 10)
              $display("mismatch exp x=%h y=%h z=%h zw=%b sat=%b got x=%h y=%h z=%h zw=%b sat=%b",
                       want.x, want.y, want.z, want.zw, want.sat,
                       got.x, got.y, got.z, got.zw, got.sat);
          end
        end
      end
      if (hold_rx > 0) begin
        hold_rx--;
        m_axis_tready <= 0;
      end else
        m_axis_tready <= calm || quit_rx || ($urandom_range(99) >= 13);
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > LIMIT_CYC) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  row_t table_rows [$];

  initial begin
    point_t pz;
    for (int i = 0; i < NUM_REGS; i++) mat_regs[i] = 0;
    mat_regs[REG_ROW0_C01] = 64'd1 << FB;
    mat_regs[REG_ROW1_C01] = 64'd1 << (FB + 32);
    mat_regs[REG_ROW2_C23] = 64'd1 << FB;
    mat_regs[REG_ROW3_C23] = 64'd1 << (FB + 32);
    repeat (2) @(posedge clk_i);
    rst_ni <= 1;

    // identity: point passes through unchanged
    pz = '0;
    table_rows.insert(table_rows.size(), '{32'h0, 32'h0, 32'h0, 1, pz});
    pz = '{32'h00010000, 32'hFFFE0000, 32'h00030000, 0, 0};
    table_rows.insert(table_rows.size(), '{32'h00010000, 32'hFFFE0000, 32'h00030000, 1, pz});
    pz = '{32'h7FFFFFFF, 32'h80000000, 32'h00000001, 0, 0};
    table_rows.insert(table_rows.size(), '{32'h7FFFFFFF, 32'h80000000, 32'h00000001, 1, pz});
    table_rows.insert(table_rows.size(), '{32'hFFFFFFFF, 32'h12345678, 32'hEDCBA987, 0, pz});
    foreach (table_rows[i]) begin
      if (table_rows[i].has_exp && project_vertex(table_rows[i].x, table_rows[i].y,
          table_rows[i].z) !== table_rows[i].exp_pt) begin
        errors++;
        $display("table row %0d predictor disagrees", i);
      end
      send_vertex(table_rows[i].x, table_rows[i].y, table_rows[i].z);
    end
    s_axis_tvalid <= 0;
    drain();

    // zero w: row 3 all zero -> nonzero components clamped, zero w flag
    write_reg(REG_ROW3_C23, 64'd0);
    send_vertex(32'h00010000, 32'hFFFF0000, 32'h0);
    send_vertex(32'h0, 32'h0, 32'h0);
    s_axis_tvalid <= 0;
    drain();
    // overflow: tiny w
    write_reg(REG_ROW3_C23, 64'd1 << 32);
    send_vertex(32'h00010000, 32'h80000000, 32'h7FFFFFFF);
    s_axis_tvalid <= 0;
    drain();
    // negative w, extremes of every element but row 3 columns 2 and 3
    write_reg(REG_ROW3_C23, 64'hFFFF0000_00000000);
    for (int i = 0; i < NUM_REGS - 1; i++) write_reg(i, 64'h80000000_7FFFFFFF);
    send_vertex(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF);
    send_vertex(32'h80000000, 32'h80000000, 32'h80000000);
    s_axis_tvalid <= 0;
    drain();
    for (int i = 0; i < NUM_REGS; i++) write_reg(i, 64'hFFFFFFFF_FFFFFFFF);
    send_vertex(32'h80000000, 32'h7FFFFFFF, 32'h00000000);
    s_axis_tvalid <= 0;
    drain();

    for (int ph = 0; ph < 10; ph++) begin
      for (int i = 0; i < NUM_REGS; i++) write_reg(i, {rnd_elem(), rnd_elem()});
      if (ph == 3) mat_regs[REG_ROW3_C23] = 0;
      if (ph == 3) write_reg(REG_ROW3_C23, 64'd0);
      calm = (ph == 5);
      if (ph == 2) hold_rx = 400;
      for (int k = 0; k < N_RANDOM / 10; k++) send_vertex(rnd_coord(), rnd_coord(), rnd_coord());
      s_axis_tvalid <= 0;
      drain();  // sender pauses until all results are in
    end
    calm = 0;
    quit_rx = 1;
    drain();
    if (errors == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end
endmodule

>>> filelist.f
rtl/hvt_pkg.sv
rtl/homogeneous_vertex_transform.sv
tb/tb_top.sv
